// ----- src/cfp_pkg.sv -----
// Shared constants and helpers for the circle-from-points core.
`timescale 1ns / 1ps
package cfp_pkg;

  // Default coordinate width and fixed-point fraction bits
  localparam int CFP_COORD_BITS = 16;
  localparam int CFP_FRAC_BITS  = 8;

  // Request mode codes
  localparam logic MODE_DIAM = 1'b0;
  localparam logic MODE_CIRC = 1'b1;

  // Clamp a signed 64-bit value to signed 32 bits; MSB of result flags a clamp
  function automatic logic [32:0] cfp_sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ----- src/circle_from_points_core.sv -----
// Circle-from-points core: diameter circle or circumcircle, fully pipelined.
//
// Input channel (in_valid / in_stall): one request carries a mode and integer
// points A, B, C. Mode 0 returns the circle on diameter AB, mode 1 the
// circumcircle of A, B, C. Output channel (out_valid / out_stall): center
// and radius in fixed point with FRAC_BITS fraction bits, plus a degenerate
// flag for collinear points or a saturated result.
// Throughput: one request per cycle unless a full pipeline backs up behind
// a stalled output. The pipeline depth is set by the divider (one quotient
// bit per stage) and the square root unit (one root bit per stage).
// Each stage carries its own valid bit; a stage loads whenever it is empty
// or the stage after it moves, so bubbles are squeezed out while the
// receiver stalls and in_stall only rises once every stage holds a request.
// A stalled result holds steady on the output register.
// Reset (synchronous, rst_n low) empties the pipeline; data is not reset.
`timescale 1ns / 1ps
module circle_from_points_core #(
  parameter int COORD_BITS = cfp_pkg::CFP_COORD_BITS,
  parameter int FRAC_BITS  = cfp_pkg::CFP_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic signed [COORD_BITS-1:0] in_ax,
  input  logic signed [COORD_BITS-1:0] in_ay,
  input  logic signed [COORD_BITS-1:0] in_bx_in,
  input  logic signed [COORD_BITS-1:0] in_by_in,
  input  logic signed [COORD_BITS-1:0] in_cx_in,
  input  logic signed [COORD_BITS-1:0] in_cy_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           out_center_x,
  output logic signed [31:0]           out_center_y,
  output logic [31:0]                  out_radius,
  output logic                         out_degenerate
);
  import cfp_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int PW   = C + 1;            // coordinate difference
  localparam int MW   = 2 * C + 2;        // product of two differences
  localparam int DETW = 2 * C + 3;        // determinant
  localparam int SQW  = 2 * C + 2;        // sum of squares
  localparam int H    = C + 1;            // split point of a sum of squares
  localparam int PPW  = 2 * C + 3;        // partial product
  localparam int NUMW = 3 * C + 4;        // center numerator
  localparam int NW   = 3 * C + F + 4;    // dividend / quotient
  localparam int DW   = 2 * C + 3;        // divisor 2|D|
  localparam int MXW  = C + F + 2;        // diameter midpoint
  localparam int SW0  = 2 * C + 2 + 2 * F;
  localparam int SW   = (SW0 > 65) ? SW0 : 65;
  localparam int SQ   = (SW + 1) / 2;     // root bits
  localparam int XW   = 2 * SQ;           // radicand

  localparam int ST_DIV0 = 6;
  localparam int ST_POST = ST_DIV0 + NW;
  localparam int ST_SQR  = ST_POST + 1;
  localparam int ST_XIN  = ST_POST + 2;
  localparam int ST_SQ0  = ST_POST + 3;
  localparam int ST_OUT  = ST_SQ0 + SQ;
  localparam int NSTG    = ST_OUT + 1;

  typedef struct packed {
    logic                mode;
    logic signed [C-1:0] ax;
    logic signed [C-1:0] ay;
    logic [31:0]         m0cx;
    logic [31:0]         m0cy;
    logic                m0f;
  } carry_t;

  typedef struct packed {
    carry_t      cr;
    logic        coll;
    logic [SQW-1:0] bq;
    logic        negx;
    logic        negy;
    logic [DW-1:0] dvs;
  } div_side_t;

  typedef struct packed {
    logic        mode;
    logic        coll;
    logic        flag;
    logic [31:0] cenx;
    logic [31:0] ceny;
    logic        radsat;
  } tail_t;

  // ---------------------------------------------------------------
  // Stage valid bits and per-stage load enables
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] en;
  logic            out_go;

  assign out_go = !out_stall;

  for (genvar k = 0; k < NSTG; k++) begin : g_en
    localparam logic [NSTG-1:0] LM = {NSTG{1'b1}} >> (NSTG - k);
    // stage k may load unless it and every stage after it are full and stalled
    assign en[k] = out_go || !(&(v_r | LM));
  end

  assign v_nxt    = (en & {v_r[NSTG-2:0], in_valid}) | (~en & v_r);
  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 0: differences and sums
  logic                 mode0_r;
  logic signed [C-1:0]  ax0_r, ay0_r;
  logic signed [PW-1:0] px0_r, py0_r, qx0_r, qy0_r, sx0_r, sy0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mode0_r <= in_mode;
      ax0_r   <= in_ax;
      ay0_r   <= in_ay;
      px0_r   <= PW'(in_bx_in) - PW'(in_ax);
      py0_r   <= PW'(in_by_in) - PW'(in_ay);
      qx0_r   <= PW'(in_cx_in) - PW'(in_ax);
      qy0_r   <= PW'(in_cy_in) - PW'(in_ay);
      sx0_r   <= PW'(in_ax) + PW'(in_bx_in);
      sy0_r   <= PW'(in_ay) + PW'(in_by_in);
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: products, diameter midpoint
  logic [PW-1:0]         sxm, sym;
  logic [MXW-1:0]        mxt, myt;
  logic signed [63:0]    mxs, mys;
  logic [32:0]           m0x_s, m0y_s;
  carry_t                cr1_r;
  logic signed [PW-1:0]  px1_r, py1_r, qx1_r, qy1_r;
  logic signed [MW-1:0]  pq1_r, qp1_r, pxx1_r, pyy1_r, qxx1_r, qyy1_r;

  // rounded |A+B| * 2^F / 2, ties away from zero
  always_comb begin
    sxm   = sx0_r[PW-1] ? PW'(-sx0_r) : PW'(sx0_r);
    sym   = sy0_r[PW-1] ? PW'(-sy0_r) : PW'(sy0_r);
    mxt   = (MXW'(sxm) << F) + MXW'(1);
    myt   = (MXW'(sym) << F) + MXW'(1);
    mxs   = sx0_r[PW-1] ? -$signed(64'(mxt >> 1)) : $signed(64'(mxt >> 1));
    mys   = sy0_r[PW-1] ? -$signed(64'(myt >> 1)) : $signed(64'(myt >> 1));
    m0x_s = cfp_sat32(mxs);
    m0y_s = cfp_sat32(mys);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cr1_r.mode <= mode0_r;
      cr1_r.ax   <= ax0_r;
      cr1_r.ay   <= ay0_r;
      cr1_r.m0cx <= m0x_s[31:0];
      cr1_r.m0cy <= m0y_s[31:0];
      cr1_r.m0f  <= m0x_s[32] | m0y_s[32];
      px1_r      <= px0_r;
      py1_r      <= py0_r;
      qx1_r      <= qx0_r;
      qy1_r      <= qy0_r;
      pq1_r      <= px0_r * qy0_r;
      qp1_r      <= py0_r * qx0_r;
      pxx1_r     <= px0_r * px0_r;
      pyy1_r     <= py0_r * py0_r;
      qxx1_r     <= qx0_r * qx0_r;
      qyy1_r     <= qy0_r * qy0_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: determinant and squared lengths
  carry_t                 cr2_r;
  logic signed [PW-1:0]   px2_r, py2_r, qx2_r, qy2_r;
  logic signed [DETW-1:0] d2_r;
  logic [SQW-1:0]         bq2_r, cq2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cr2_r <= cr1_r;
      px2_r <= px1_r;
      py2_r <= py1_r;
      qx2_r <= qx1_r;
      qy2_r <= qy1_r;
      d2_r  <= DETW'(pq1_r) - DETW'(qp1_r);
      bq2_r <= SQW'(pxx1_r) + SQW'(pyy1_r);
      cq2_r <= SQW'(qxx1_r) + SQW'(qyy1_r);
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: partial products of the numerators, split at bit H
  carry_t                 cr3_r;
  logic signed [DETW-1:0] d3_r;
  logic [SQW-1:0]         bq3_r;
  logic signed [PPW-1:0]  qyb_lo_r, qyb_hi_r, pyc_lo_r, pyc_hi_r;
  logic signed [PPW-1:0]  pxc_lo_r, pxc_hi_r, qxb_lo_r, qxb_hi_r;
  logic signed [H:0]      blo, bhi, clo, chi;

  assign blo = $signed({1'b0, bq2_r[H-1:0]});
  assign bhi = $signed({1'b0, bq2_r[2*H-1:H]});
  assign clo = $signed({1'b0, cq2_r[H-1:0]});
  assign chi = $signed({1'b0, cq2_r[2*H-1:H]});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      cr3_r    <= cr2_r;
      d3_r     <= d2_r;
      bq3_r    <= bq2_r;
      qyb_lo_r <= qy2_r * blo;
      qyb_hi_r <= qy2_r * bhi;
      pyc_lo_r <= py2_r * clo;
      pyc_hi_r <= py2_r * chi;
      pxc_lo_r <= px2_r * clo;
      pxc_hi_r <= px2_r * chi;
      qxb_lo_r <= qx2_r * blo;
      qxb_hi_r <= qx2_r * bhi;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: combine partials into the center numerators
  carry_t                 cr4_r;
  logic signed [DETW-1:0] d4_r;
  logic [SQW-1:0]         bq4_r;
  logic signed [NUMW-1:0] numx4_r, numy4_r;
  logic                   coll4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      cr4_r   <= cr3_r;
      d4_r    <= d3_r;
      bq4_r   <= bq3_r;
      coll4_r <= (cr3_r.mode == MODE_CIRC) && (d3_r == '0);
      numx4_r <= ((NUMW'(qyb_hi_r) - NUMW'(pyc_hi_r)) <<< H)
               + (NUMW'(qyb_lo_r) - NUMW'(pyc_lo_r));
      numy4_r <= ((NUMW'(pxc_hi_r) - NUMW'(qxb_hi_r)) <<< H)
               + (NUMW'(pxc_lo_r) - NUMW'(qxb_lo_r));
    end
  end

  // ---------------------------------------------------------------
  // Stage 5: dividend |N| * 2^F + |D| and divisor 2|D|
  logic [NUMW-1:0] amx, amy;
  logic [DETW-1:0] ad;
  logic [NW-1:0]   mx5_r, my5_r;
  div_side_t       ds5_r;

  always_comb begin
    amx = numx4_r[NUMW-1] ? NUMW'(-numx4_r) : NUMW'(numx4_r);
    amy = numy4_r[NUMW-1] ? NUMW'(-numy4_r) : NUMW'(numy4_r);
    ad  = d4_r[DETW-1] ? DETW'(-d4_r) : DETW'(d4_r);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      mx5_r      <= (NW'(amx) << F) + NW'(ad);
      my5_r      <= (NW'(amy) << F) + NW'(ad);
      ds5_r.cr   <= cr4_r;
      ds5_r.coll <= coll4_r;
      ds5_r.bq   <= bq4_r;
      ds5_r.negx <= numx4_r[NUMW-1] ^ d4_r[DETW-1];
      ds5_r.negy <= numy4_r[NUMW-1] ^ d4_r[DETW-1];
      // a zero determinant gets a harmless divisor; its result is discarded
      ds5_r.dvs  <= (d4_r == '0) ? DW'(2) : DW'({ad, 1'b0});
    end
  end

  // ---------------------------------------------------------------
  // Divider pipeline, x and y lanes side by side
  logic [DW-1:0] drx [NW];
  logic [DW-1:0] dry [NW];
  logic [NW-1:0] dqx [NW];
  logic [NW-1:0] dqy [NW];
  div_side_t     ds_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_div
    logic [DW-1:0] rxi, ryi;
    logic [NW-1:0] qxi, qyi;
    div_side_t     sdi;

    if (i == 0) begin : g_head
      assign rxi = '0;
      assign ryi = '0;
      assign qxi = mx5_r;
      assign qyi = my5_r;
      assign sdi = ds5_r;
    end else begin : g_body
      assign rxi = drx[i-1];
      assign ryi = dry[i-1];
      assign qxi = dqx[i-1];
      assign qyi = dqy[i-1];
      assign sdi = ds_r[i-1];
    end

    cfp_div_step #(.NW(NW), .DW(DW)) u_divx (
      .clk   (clk),
      .en    (en[ST_DIV0+i]),
      .dvs_i (sdi.dvs),
      .rem_i (rxi),
      .quo_i (qxi),
      .rem_r (drx[i]),
      .quo_r (dqx[i])
    );

    cfp_div_step #(.NW(NW), .DW(DW)) u_divy (
      .clk   (clk),
      .en    (en[ST_DIV0+i]),
      .dvs_i (sdi.dvs),
      .rem_i (ryi),
      .quo_i (qyi),
      .rem_r (dry[i]),
      .quo_r (dqy[i])
    );

    always_ff @(posedge clk) begin
      if (en[ST_DIV0+i]) begin
        ds_r[i] <= sdi;
      end
    end
  end

  // ---------------------------------------------------------------
  // Post-divide: signed offsets and range checks
  logic [NW-1:0]      qfx, qfy;
  div_side_t          psd_r;
  logic signed [63:0] uxx_r, uxy_r;
  logic               hx_r, hy_r, bgx_r, bgy_r;
  logic [31:0]        m32x_r, m32y_r;

  assign qfx = dqx[NW-1];
  assign qfy = dqy[NW-1];

  always_ff @(posedge clk) begin
    if (en[ST_POST]) begin
      psd_r  <= ds_r[NW-1];
      hx_r   <= (qfx >> 62) != '0;
      hy_r   <= (qfy >> 62) != '0;
      bgx_r  <= (qfx >> 32) != '0;
      bgy_r  <= (qfy >> 32) != '0;
      uxx_r  <= ds_r[NW-1].negx ? -$signed(64'(qfx)) : $signed(64'(qfx));
      uxy_r  <= ds_r[NW-1].negy ? -$signed(64'(qfy)) : $signed(64'(qfy));
      m32x_r <= 32'(qfx);
      m32y_r <= 32'(qfy);
    end
  end

  // ---------------------------------------------------------------
  // Center = A * 2^F + offset, squared offset magnitudes
  logic [32:0]    cx_s, cy_s;
  logic [31:0]    cxv, cyv;
  tail_t          t1_r;
  logic [SQW-1:0] bq1_r;
  logic [63:0]    sqx_r, sqy_r;

  always_comb begin
    cx_s = cfp_sat32((64'(psd_r.cr.ax) <<< F) + uxx_r);
    cy_s = cfp_sat32((64'(psd_r.cr.ay) <<< F) + uxy_r);
    cxv  = hx_r ? (psd_r.negx ? 32'h8000_0000 : 32'h7FFF_FFFF) : cx_s[31:0];
    cyv  = hy_r ? (psd_r.negy ? 32'h8000_0000 : 32'h7FFF_FFFF) : cy_s[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[ST_SQR]) begin
      t1_r.mode   <= psd_r.cr.mode;
      t1_r.coll   <= psd_r.coll;
      if (psd_r.cr.mode == MODE_CIRC) begin
        t1_r.flag   <= hx_r | hy_r | cx_s[32] | cy_s[32];
        t1_r.cenx   <= cxv;
        t1_r.ceny   <= cyv;
        t1_r.radsat <= hx_r | hy_r | bgx_r | bgy_r;
      end else begin
        t1_r.flag   <= psd_r.cr.m0f;
        t1_r.cenx   <= psd_r.cr.m0cx;
        t1_r.ceny   <= psd_r.cr.m0cy;
        t1_r.radsat <= 1'b0;
      end
      bq1_r <= psd_r.bq;
      sqx_r <= m32x_r * m32x_r;
      sqy_r <= m32y_r * m32y_r;
    end
  end

  // ---------------------------------------------------------------
  // Radicand select: |offset|^2 or |AB|^2 * 2^(2F)
  tail_t         t2_r;
  logic [XW-1:0] x2_r;

  always_ff @(posedge clk) begin
    if (en[ST_XIN]) begin
      t2_r <= t1_r;
      if (t1_r.mode == MODE_CIRC) begin
        x2_r <= XW'(sqx_r) + XW'(sqy_r);
      end else begin
        x2_r <= XW'(bq1_r) << (2 * F);
      end
    end
  end

  // ---------------------------------------------------------------
  // Square root pipeline
  logic [XW-1:0] sqx_a  [SQ];
  logic [SQ+1:0] sqr_a  [SQ];
  logic [SQ-1:0] sqn_a  [SQ];
  tail_t         tl_r   [SQ];

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    logic [XW-1:0] xi;
    logic [SQ+1:0] ri;
    logic [SQ-1:0] ni;
    tail_t         ti;

    if (j == 0) begin : g_head
      assign xi = x2_r;
      assign ri = '0;
      assign ni = '0;
      assign ti = t2_r;
    end else begin : g_body
      assign xi = sqx_a[j-1];
      assign ri = sqr_a[j-1];
      assign ni = sqn_a[j-1];
      assign ti = tl_r[j-1];
    end

    cfp_sqrt_step #(.SQ(SQ)) u_sqrt (
      .clk    (clk),
      .en     (en[ST_SQ0+j]),
      .x_i    (xi),
      .rem_i  (ri),
      .root_i (ni),
      .x_r    (sqx_a[j]),
      .rem_r  (sqr_a[j]),
      .root_r (sqn_a[j])
    );

    always_ff @(posedge clk) begin
      if (en[ST_SQ0+j]) begin
        tl_r[j] <= ti;
      end
    end
  end

  // ---------------------------------------------------------------
  // Output stage: round the root, saturate, assemble the result
  tail_t         tf;
  logic [SQ-1:0] rn;
  logic [SQ+1:0] rr;
  logic [SQ:0]   rad_v;
  logic          rad_big;
  logic [31:0]   out_center_x_r, out_center_y_r, out_radius_r;
  logic          out_degenerate_r;

  always_comb begin
    tf = tl_r[SQ-1];
    rn = sqn_a[SQ-1];
    rr = sqr_a[SQ-1];
    if (tf.mode == MODE_CIRC) begin
      // round to nearest: bump when x - n^2 exceeds n
      rad_v = (SQ+1)'(rn) + (SQ+1)'(rr > (SQ+2)'(rn));
    end else begin
      rad_v = ((SQ+1)'(rn) + (SQ+1)'(1)) >> 1;
    end
    rad_big = (rad_v >> 32) != '0;
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      if (tf.coll) begin
        out_center_x_r   <= '0;
        out_center_y_r   <= '0;
        out_radius_r     <= '0;
        out_degenerate_r <= 1'b1;
      end else begin
        out_center_x_r   <= tf.cenx;
        out_center_y_r   <= tf.ceny;
        out_radius_r     <= (tf.radsat | rad_big) ? 32'hFFFF_FFFF : rad_v[31:0];
        out_degenerate_r <= tf.flag | tf.radsat | rad_big;
      end
    end
  end

  assign out_valid      = v_r[NSTG-1];
  assign out_center_x   = $signed(out_center_x_r);
  assign out_center_y   = $signed(out_center_y_r);
  assign out_radius     = out_radius_r;
  assign out_degenerate = out_degenerate_r;

endmodule

// ----- src/cfp_div_step.sv -----
// One restoring-division step: one quotient bit per pipeline stage.
`timescale 1ns / 1ps
module cfp_div_step #(
  parameter int NW = 60,
  parameter int DW = 35
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dvs_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] quo_i,
  output logic [DW-1:0] rem_r,
  output logic [NW-1:0] quo_r
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // shift in next dividend bit and try subtracting the divisor
  assign trial = {rem_i, quo_i[NW-1]};
  assign diff  = trial - {1'b0, dvs_i};
  assign ge    = trial >= {1'b0, dvs_i};

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_i[NW-2:0], ge};
    end
  end

endmodule

// ----- src/cfp_sqrt_step.sv -----
// One digit-by-digit square root step: one root bit per pipeline stage.
`timescale 1ns / 1ps
module cfp_sqrt_step #(
  parameter int SQ = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*SQ-1:0] x_i,
  input  logic [SQ+1:0]   rem_i,
  input  logic [SQ-1:0]   root_i,
  output logic [2*SQ-1:0] x_r,
  output logic [SQ+1:0]   rem_r,
  output logic [SQ-1:0]   root_r
);

  localparam int XW = 2 * SQ;
  localparam int TW = SQ + 4;

  logic [TW-1:0] tval;
  logic [TW-1:0] trial;
  logic [TW-1:0] diff;
  logic          ge;

  // bring down two radicand bits, trial subtract 4*root+1
  assign tval  = {rem_i, x_i[XW-1:XW-2]};
  assign trial = TW'({root_i, 2'b01});
  assign diff  = tval - trial;
  assign ge    = tval >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= {x_i[XW-3:0], 2'b00};
      rem_r  <= ge ? diff[SQ+1:0] : tval[SQ+1:0];
      root_r <= {root_i[SQ-2:0], ge};
    end
  end

endmodule

// ----- src/cfp_checker.sv -----
// Port-level checks for the circle-from-points core, bound to the top level.
`timescale 1ns / 1ps
module cfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_center_x,
  input logic [31:0] out_center_y,
  input logic [31:0] out_radius,
  input logic        out_degenerate
);

  logic [15:0] cnt_r;
  logic [15:0] cnt_nxt;
  logic        in_acc;
  logic        out_acc;

  // requests in flight
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 16'd1;
    end else if (!in_acc && out_acc) begin
      cnt_nxt = cnt_r - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // input is only held off when a full pipeline backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // every result belongs to an accepted request
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != 16'd0))
    else $error("result without an outstanding request");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_center_x)
      && $stable(out_center_y) && $stable(out_radius) && $stable(out_degenerate)))
    else $error("stalled result changed");

endmodule

bind circle_from_points_core cfp_checker u_cfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_center_x   (out_center_x),
  .out_center_y   (out_center_y),
  .out_radius     (out_radius),
  .out_degenerate (out_degenerate)
);

// ----- sim/circle_from_points_core_test.sv -----
// Testbench for the circle-from-points core: self-checking, with its own circle predictor.
`timescale 1ns / 1ps
module circle_from_points_core_test;
  import cfp_pkg::*;

  localparam int CB = CFP_COORD_BITS;
  localparam int FB = CFP_FRAC_BITS;
  localparam int PIPE_DEPTH = 3 * CB + FB + 14 + 66;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic                 mode;
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
  } point_set_t;

  typedef struct {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [31:0]        radius;
    logic               degenerate;
  } circle_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic signed [CB-1:0] in_ax = '0, in_ay = '0, in_bx_in = '0;
  logic signed [CB-1:0] in_by_in = '0, in_cx_in = '0, in_cy_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_center_x, out_center_y;
  logic [31:0] out_radius;
  logic out_degenerate;

  circle_t circle_queue[$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  bit      quiet = 1'b0;
  bit      run_done = 1'b0;

  circle_from_points_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (.*);

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- circle predictor ----------------
  function automatic logic [63:0] root_floor(input logic [127:0] x);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp_s32(input logic signed [63:0] v, inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] clamp_u32(input logic [63:0] v, inout logic flag);
    if (v > 64'hFFFF_FFFF) begin
      flag = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

  // rounded num * 2^FB / (2d), ties away from zero; huge when it reaches 2^62
  function automatic logic signed [63:0] center_offset(input logic signed [127:0] num,
      input logic signed [63:0] d, output logic huge, output logic [63:0] mag);
    logic        neg;
    logic [127:0] ad, m, q;
    neg = num[127];
    ad = (d < 0) ? -d : d;
    m = neg ? -num : num;
    m = (m << FB) + ad;
    q = m / (ad << 1);
    if (d < 0) neg = !neg;
    huge = 1'b0;
    if (q[127:64] != 0 || q[63:0] >= (64'd1 << 62)) begin
      huge = 1'b1;
      mag = '0;
      return neg ? -64'sd1 : 64'sd1;
    end
    mag = q[63:0];
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic circle_t predict_circle(input point_set_t p);
    circle_t r;
    logic signed [63:0] ax, ay, bx, by, cx, cy, sx, sy, px, py, qx, qy, d, ux, uy;
    logic signed [127:0] wpx, wpy, wqx, wqy, wbq, wcq;
    logic [63:0] mx, my, d2, umx, umy, n;
    logic [127:0] x;
    logic flag, hx, hy;
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by; cx = p.cx; cy = p.cy;
    flag = 1'b0;
    if (p.mode == MODE_DIAM) begin
      sx = ax + bx;
      sy = ay + by;
      mx = (((sx < 0) ? -sx : sx) * (64'd1 << FB) + 1) >> 1;
      my = (((sy < 0) ? -sy : sy) * (64'd1 << FB) + 1) >> 1;
      d2 = (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
      r.center_x = clamp_s32((sx < 0) ? -$signed(mx) : $signed(mx), flag);
      r.center_y = clamp_s32((sy < 0) ? -$signed(my) : $signed(my), flag);
      x = {64'd0, d2} << (2 * FB);
      r.radius = clamp_u32((root_floor(x) + 1) >> 1, flag);
    end else begin
      px = bx - ax; py = by - ay; qx = cx - ax; qy = cy - ay;
      d = px * qy - py * qx;
      if (d == 0) begin
        r.center_x = '0; r.center_y = '0; r.radius = '0; r.degenerate = 1'b1;
        return r;
      end
      wpx = px; wpy = py; wqx = qx; wqy = qy;
      wbq = px * px + py * py;
      wcq = qx * qx + qy * qy;
      ux = center_offset(wqy * wbq - wpy * wcq, d, hx, umx);
      uy = center_offset(wpx * wcq - wqx * wbq, d, hy, umy);
      if (hx) begin
        flag = 1'b1;
        r.center_x = (ux < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else r.center_x = clamp_s32(ax * (64'sd1 <<< FB) + ux, flag);
      if (hy) begin
        flag = 1'b1;
        r.center_y = (uy < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else r.center_y = clamp_s32(ay * (64'sd1 <<< FB) + uy, flag);
      if (hx || hy) r.radius = 32'hFFFF_FFFF;
      else begin
        x = {64'd0, umx} * {64'd0, umx} + {64'd0, umy} * {64'd0, umy};
        n = root_floor(x);
        if (x > {64'd0, n} * {64'd0, n} + n) n = n + 1;
        r.radius = clamp_u32(n, flag);
      end
    end
    r.degenerate = flag;
    return r;
  endfunction

  // ---------------- request driver ----------------
  task automatic send_points(input point_set_t p);
    bit taken;
    // insert random idle cycles, about a third of all cycles
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= p.mode;
    in_ax <= p.ax; in_ay <= p.ay; in_bx_in <= p.bx;
    in_by_in <= p.by; in_cx_in <= p.cx; in_cy_in <= p.cy;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) circle_queue.push_back(predict_circle(p));
      @(posedge clk);
    end
  endtask

  task automatic send_vals(input logic mode, input int ax, ay, bx, by, cx, cy);
    point_set_t p;
    p.mode = mode;
    p.ax = CB'(ax); p.ay = CB'(ay); p.bx = CB'(bx);
    p.by = CB'(by); p.cx = CB'(cx); p.cy = CB'(cy);
    send_points(p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (circle_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  // ---------------- result checker ----------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // receiver stall
  always @(posedge clk) out_stall <= !quiet && ($urandom_range(99) < 32);

  // results are checked at the falling edge ahead of their transfer edge
  always @(negedge clk) begin
    circle_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (circle_queue.size() == 0) begin
        report_mismatch("unexpected result", out_radius, 32'd0);
      end else begin
        want = circle_queue.pop_front();
        if (out_center_x !== want.center_x)
          report_mismatch("center_x", out_center_x, want.center_x);
        if (out_center_y !== want.center_y)
          report_mismatch("center_y", out_center_y, want.center_y);
        if (out_radius !== want.radius) report_mismatch("radius", out_radius, want.radius);
        if (out_degenerate !== want.degenerate)
          report_mismatch("degenerate", 32'(out_degenerate), 32'(want.degenerate));
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT && !run_done) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_diameter();
    send_vals(MODE_DIAM, 0, 0, 0, 0, 0, 0);
    send_vals(MODE_DIAM, 5, 5, 5, 5, 1, 2);
    send_vals(MODE_DIAM, 0, 0, 3, 4, 0, 0);
    send_vals(MODE_DIAM, 1, 0, 0, 0, -7, 9);
    send_vals(MODE_DIAM, -1, -2, -2, -1, 0, 0);
    send_vals(MODE_DIAM, -32768, -32768, 32767, 32767, -32768, 32767);
    send_vals(MODE_DIAM, 32767, 32767, 32767, 32767, 32767, 32767);
    send_vals(MODE_DIAM, -32768, -32768, -32768, -32768, -32768, -32768);
  endtask

  task automatic test_circumcircle();
    send_vals(MODE_CIRC, 0, 0, 4, 0, 0, 3);
    send_vals(MODE_CIRC, 1, 1, -3, 2, 5, -7);
    send_vals(MODE_CIRC, -32768, -32768, 32767, -32768, -32768, 32767);
    send_vals(MODE_CIRC, 32767, 32767, -32768, 32767, 32767, -32768);
    send_vals(MODE_CIRC, 0, 0, 1, 0, 0, -1);
  endtask

  task automatic test_collinear();
    send_vals(MODE_CIRC, 0, 0, 0, 0, 0, 0);
    send_vals(MODE_CIRC, 3, 4, 3, 4, -9, 2);
    send_vals(MODE_CIRC, -32768, -32768, 0, 0, 32767, 32767);
    send_vals(MODE_CIRC, 1, 2, 3, 4, 5, 6);
  endtask

  // nearly collinear: center far away, saturates
  task automatic test_saturation();
    send_vals(MODE_CIRC, -32768, 0, 32767, 1, 0, 0);
    send_vals(MODE_CIRC, -32768, -32768, 32767, 32766, 0, 0);
    send_vals(MODE_CIRC, 0, -32768, 1, 32767, 0, 0);
    send_vals(MODE_CIRC, 32767, -32768, -32768, 32767, 1, 0);
  endtask

  function automatic logic signed [CB-1:0] rand_coord(input int span);
    if (span == 0) return CB'($urandom);
    return CB'($signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic test_random(input int count);
    point_set_t p;
    int span, k, kind;
    for (int i = 0; i < count; i++) begin
      quiet = (i >= 300 && i < 450);
      if (i == 600) drain_results();
      span = ($urandom_range(2) == 0) ? 0 : (1 << $urandom_range(2, 12));
      p.mode = 1'($urandom);
      p.ax = rand_coord(span); p.ay = rand_coord(span);
      p.bx = rand_coord(span); p.by = rand_coord(span);
      p.cx = rand_coord(span); p.cy = rand_coord(span);
      kind = $urandom_range(9);
      if (p.mode == MODE_CIRC && kind < 2) begin
        // C on or next to line AB
        k = $urandom_range(4) - 2;
        p.bx = p.ax + rand_coord(200); p.by = p.ay + rand_coord(200);
        p.cx = CB'(p.ax + k * (p.bx - p.ax) + (kind == 1 ? rand_coord(1) : 0));
        p.cy = CB'(p.ay + k * (p.by - p.ay));
      end else if (kind == 2) begin
        p.bx = p.ax; p.by = p.ay;
      end
      send_points(p);
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_diameter();
    test_circumcircle();
    test_collinear();
    test_saturation();
    test_random(880);
    drain_results();
    run_done = 1'b1;
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
